>>> src/lfd_pkg.sv
// Shared types and constants of the byte ring log FIFO device.
package lfd_pkg;

    localparam int FIFO_DEPTH  = 65536;
    localparam int ADDR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = ADDR_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CMD_W     = 4;
    localparam int SIZE_W    = 2;
    localparam int WDATA_W   = 64;
    localparam int RDATA_W   = 64;
    localparam int SIGNO_W   = 6;
    localparam int ARG_W     = 8;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;
    localparam int LEFT_W    = 4;

    localparam logic [CMD_W-1:0] CMD_PUT     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_COUNT   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ENABLE  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_ACK     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_OPEN    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CLOSE   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_MAP     = 4'd7;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 4'd8;

    typedef enum logic [3:0] {
        OP_PUT,
        OP_READ,
        OP_COUNT,
        OP_ENABLE,
        OP_ACK,
        OP_OPEN,
        OP_CLOSE,
        OP_MAP,
        OP_UNKNOWN,
        OP_NONE
    } t_op;

    // one classified word as held in the queue
    typedef struct packed {
        t_op               op;
        logic [SIZE_W-1:0] size_code;
        logic [ARG_W-1:0]  arg;
    } t_entry;

    // queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_back_state;

endpackage

>>> src/lfd_front.sv
// Front end: accept input words, decode the command and push into the queue.
module lfd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [lfd_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  lfd_pkg::t_queue_status             i_q_status,
    output logic                               o_push,
    output lfd_pkg::t_entry                    o_entry
);

    logic [lfd_pkg::CMD_W-1:0]   w_cmd;
    logic [lfd_pkg::SIZE_W-1:0]  w_size;
    logic [lfd_pkg::WDATA_W-1:0] w_wdata;
    lfd_pkg::t_op                w_op;
    logic                        r_ready;

    assign w_cmd   = i_s_tdata[lfd_pkg::CMD_W-1:0];
    assign w_size  = i_s_tdata[lfd_pkg::CMD_W +: lfd_pkg::SIZE_W];
    assign w_wdata = i_s_tdata[lfd_pkg::CMD_W+lfd_pkg::SIZE_W +: lfd_pkg::WDATA_W];

    always_comb begin
        unique case (w_cmd)
            lfd_pkg::CMD_PUT:     w_op = lfd_pkg::OP_PUT;
            lfd_pkg::CMD_READ:    w_op = lfd_pkg::OP_READ;
            lfd_pkg::CMD_COUNT:   w_op = lfd_pkg::OP_COUNT;
            lfd_pkg::CMD_ENABLE:  w_op = lfd_pkg::OP_ENABLE;
            lfd_pkg::CMD_ACK:     w_op = lfd_pkg::OP_ACK;
            lfd_pkg::CMD_OPEN:    w_op = lfd_pkg::OP_OPEN;
            lfd_pkg::CMD_CLOSE:   w_op = lfd_pkg::OP_CLOSE;
            lfd_pkg::CMD_MAP:     w_op = lfd_pkg::OP_MAP;
            lfd_pkg::CMD_UNKNOWN: w_op = lfd_pkg::OP_UNKNOWN;
            default:              w_op = lfd_pkg::OP_NONE;
        endcase
    end

    // hold ready low during reset so nothing is taken before the queue is clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= 1'b1;
        end
    end

    assign o_s_tready        = r_ready && !i_q_status.full;
    assign o_push            = i_s_tvalid && o_s_tready;
    assign o_entry.op        = w_op;
    assign o_entry.size_code = w_size;
    assign o_entry.arg       = w_wdata[lfd_pkg::ARG_W-1:0];

endmodule

>>> src/lfd_queue.sv
// Short queue of decoded words between the front and the back.
module lfd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  lfd_pkg::t_entry        i_entry,
    input  logic                   i_pop,
    output lfd_pkg::t_entry        o_entry,
    output lfd_pkg::t_queue_status o_status
);

    lfd_pkg::t_entry                r_slot [lfd_pkg::QUEUE_DEPTH];
    logic [lfd_pkg::QPTR_W-1:0]     r_wptr;
    logic [lfd_pkg::QPTR_W-1:0]     r_rptr;
    logic [lfd_pkg::QPTR_W:0]       r_fill;
    logic                           w_push;
    logic                           w_pop;

    assign o_status.full  = (r_fill == (lfd_pkg::QPTR_W+1)'(lfd_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign w_push         = i_push && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_entry        = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

>>> src/lfd_back.sv
// Back end: byte ring memory, device registers, read sequencer and result register.
module lfd_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lfd_pkg::t_entry                    i_entry,
    input  lfd_pkg::t_queue_status             i_q_status,
    output logic                               o_pop,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [lfd_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    logic [7:0]                    r_mem [lfd_pkg::FIFO_DEPTH];
    logic [7:0]                    r_mem_q;
    logic [lfd_pkg::ADDR_W-1:0]    w_mem_addr;
    logic                          w_mem_we;
    logic                          w_mem_re;

    lfd_pkg::t_back_state          r_state, n_state;
    logic [lfd_pkg::ADDR_W-1:0]    r_rd_idx, n_rd_idx;
    logic [lfd_pkg::ADDR_W-1:0]    r_wr_idx, n_wr_idx;
    logic [lfd_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                          r_en, n_en;
    logic                          r_stat, n_stat;
    logic [lfd_pkg::SIGNO_W-1:0]   r_map, n_map;
    logic                          r_busy, n_busy;
    logic [lfd_pkg::LEFT_W-1:0]    r_left, n_left;
    logic                          r_pend, n_pend;
    logic                          r_pend_mem, n_pend_mem;
    logic [lfd_pkg::RDATA_W-1:0]   r_acc, n_acc;
    logic                          r_out_valid, n_out_valid;
    logic [lfd_pkg::OUT_TDATA_W-1:0] r_out, n_out;

    logic                          w_out_free;
    logic                          w_take;
    logic [lfd_pkg::ADDR_W-1:0]    w_wr_next;
    logic [lfd_pkg::ADDR_W-1:0]    w_rd_next;
    logic                          w_nonempty;
    logic [lfd_pkg::RDATA_W-1:0]   w_acc_shift;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_take     = (r_state == lfd_pkg::ST_IDLE) && w_out_free && !i_q_status.empty;
    assign o_pop      = w_take;

    assign w_wr_next = (r_wr_idx == lfd_pkg::ADDR_W'(lfd_pkg::FIFO_DEPTH - 1)) ?
                       '0 : lfd_pkg::ADDR_W'(r_wr_idx + 1'b1);
    assign w_rd_next = (r_rd_idx == lfd_pkg::ADDR_W'(lfd_pkg::FIFO_DEPTH - 1)) ?
                       '0 : lfd_pkg::ADDR_W'(r_rd_idx + 1'b1);
    assign w_nonempty = (r_rd_idx != r_wr_idx);
    assign w_acc_shift = {r_acc[lfd_pkg::RDATA_W-9:0], (r_pend_mem ? r_mem_q : 8'h00)};

    // one port: puts write at the write index, reads fetch at the read index
    assign w_mem_we   = w_take && (i_entry.op == lfd_pkg::OP_PUT) && (w_wr_next != r_rd_idx);
    assign w_mem_re   = (r_state == lfd_pkg::ST_READ) && (r_left != '0) && w_nonempty;
    assign w_mem_addr = w_mem_we ? r_wr_idx : r_rd_idx;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= i_entry.arg;
        end
        if (w_mem_re) begin
            r_mem_q <= r_mem[w_mem_addr];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfd_pkg::ST_IDLE: begin
                if (w_take && (i_entry.op == lfd_pkg::OP_READ)) begin
                    n_state = lfd_pkg::ST_READ;
                end
            end
            lfd_pkg::ST_READ: begin
                if ((r_left == '0) && r_pend) begin
                    n_state = lfd_pkg::ST_IDLE;
                end
            end
            default: n_state = lfd_pkg::ST_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_cnt       = r_cnt;
        n_en        = r_en;
        n_stat      = r_stat;
        n_map       = r_map;
        n_busy      = r_busy;
        n_left      = r_left;
        n_pend      = 1'b0;
        n_pend_mem  = 1'b0;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_m_tready;

        unique case (r_state)
            lfd_pkg::ST_IDLE: begin
                if (w_take) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    unique case (i_entry.op)
                        lfd_pkg::OP_PUT: begin
                            if (w_wr_next != r_rd_idx) begin
                                n_wr_idx = w_wr_next;
                                n_cnt    = r_cnt + 1'b1;
                            end
                            if (r_en && !r_stat && (r_map != '0)) begin
                                n_out[lfd_pkg::RDATA_W+1] = 1'b1;
                                n_out[lfd_pkg::RDATA_W+2 +: lfd_pkg::SIGNO_W] = r_map;
                            end
                            n_stat = 1'b1;
                        end
                        lfd_pkg::OP_READ: begin
                            // result goes out when the sequencer finishes
                            n_out_valid = 1'b0;
                            n_left = lfd_pkg::LEFT_W'(1) << i_entry.size_code;
                            n_acc  = '0;
                        end
                        lfd_pkg::OP_COUNT: begin
                            n_out[lfd_pkg::RDATA_W-1:0] = lfd_pkg::RDATA_W'(r_cnt);
                        end
                        lfd_pkg::OP_ENABLE: begin
                            n_en = i_entry.arg[0];
                        end
                        lfd_pkg::OP_ACK: begin
                            if (i_entry.arg[0]) begin
                                n_stat = 1'b0;
                            end
                        end
                        lfd_pkg::OP_OPEN: begin
                            if (r_busy) begin
                                n_out[lfd_pkg::RDATA_W] = 1'b1;
                            end else begin
                                n_en   = 1'b0;
                                n_stat = 1'b0;
                                n_map  = '0;
                                n_busy = 1'b1;
                            end
                        end
                        lfd_pkg::OP_CLOSE: begin
                            n_en   = 1'b0;
                            n_stat = 1'b0;
                            n_map  = '0;
                            n_busy = 1'b0;
                        end
                        lfd_pkg::OP_MAP: begin
                            n_map = i_entry.arg[lfd_pkg::SIGNO_W-1:0];
                        end
                        lfd_pkg::OP_UNKNOWN: begin
                            n_out[lfd_pkg::RDATA_W-1:0] = '1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lfd_pkg::ST_READ: begin
                // shift in the byte fetched last cycle, zero when the ring was empty
                if (r_pend) begin
                    n_acc = w_acc_shift;
                end
                if (r_left != '0) begin
                    n_left     = r_left - 1'b1;
                    n_pend     = 1'b1;
                    n_pend_mem = w_nonempty;
                    if (w_nonempty) begin
                        n_rd_idx = w_rd_next;
                        n_cnt    = r_cnt - 1'b1;
                    end
                end else if (r_pend) begin
                    n_out_valid = 1'b1;
                    n_out       = lfd_pkg::OUT_TDATA_W'(w_acc_shift);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfd_pkg::ST_IDLE;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_cnt       <= '0;
            r_en        <= 1'b0;
            r_stat      <= 1'b0;
            r_map       <= '0;
            r_busy      <= 1'b0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_pend_mem  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_cnt       <= n_cnt;
            r_en        <= n_en;
            r_stat      <= n_stat;
            r_map       <= n_map;
            r_busy      <= n_busy;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_pend_mem  <= n_pend_mem;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_out <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

endmodule

>>> src/log_fifo_device.sv
// Top level of the byte ring log FIFO device with data-available interrupt.
// Usage:
//   Slave channel (i_s_tvalid/o_s_tready/i_s_tdata) carries one command word
//   per handshake: put byte, read 1/2/4/8 bytes, read fill count, write
//   interrupt enable, acknowledge status, open, close, map signal, read of an
//   unknown port. Every accepted word yields exactly one result word on the
//   master channel (o_m_tvalid/i_m_tready/o_m_tdata), in order.
//   A front end decodes words into a four-deep queue; the back end owns the
//   64K x 8 single-port byte ring and executes one word at a time.
// Throughput:
//   Non-read words pass through the queue to the result register; the back
//   end retires one per cycle while its result register is free.
//   Reads of N bytes (N = 1, 2, 4, 8): the back end fetches one byte a cycle
//   from the single memory port and takes no new word until the read is done.
// Reset: synchronous, active low; indices, count, enable, status, mapping and
//   busy clear, the queue empties. Ring contents are not cleared: only bytes
//   between the read and write indices are ever read.
// Backpressure: a held result stalls the back end; the queue then fills and
//   o_s_tready drops once four words are waiting.
module log_fifo_device (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave: [3:0] command, [5:4] size_code, [69:6] write_data, [71:70] zero
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [lfd_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // master: [63:0] read_data, [64] open_refused, [65] raise_signal,
    //         [71:66] signal_number
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [lfd_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    lfd_pkg::t_queue_status w_q_status;
    lfd_pkg::t_entry        w_push_entry;
    lfd_pkg::t_entry        w_head_entry;
    logic                   w_push;
    logic                   w_pop;

    // decode and enqueue
    lfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_entry    (w_push_entry)
    );

    // decouple decode from execution
    lfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_entry  (w_head_entry),
        .o_status (w_q_status)
    );

    // execute against the ring and device registers
    lfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (w_head_entry),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
